### src/mmbd_pkg.sv
// Package for the memory map bus decoder: channel structs, target and command codes,
// decoded-entry type and fixed address constants.
// No dependencies.
package mmbd_pkg;

   localparam int RAM_WORDS_DEF = 524288;
   localparam int ROM_WORDS_DEF = 131072;
   localparam int QUEUE_DEPTH   = 2;
   // Word index carried between front and back; covers the largest RAM and ROM.
   localparam int IDX_W         = 20;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;

   localparam logic [3:0] TGT_RAM       = 4'd0;
   localparam logic [3:0] TGT_ROM       = 4'd1;
   localparam logic [3:0] TGT_EXP       = 4'd2;
   localparam logic [3:0] TGT_IRQ_STAT  = 4'd3;
   localparam logic [3:0] TGT_IRQ_MASK  = 4'd4;
   localparam logic [3:0] TGT_DMA       = 4'd5;
   localparam logic [3:0] TGT_GPU       = 4'd6;
   localparam logic [3:0] TGT_SPU       = 4'd7;
   localparam logic [3:0] TGT_MEMCTRL   = 4'd8;
   localparam logic [3:0] TGT_CACHECTRL = 4'd9;
   localparam logic [3:0] TGT_DISCARD   = 4'd10;
   localparam logic [3:0] TGT_UNMAPPED  = 4'd11;

   localparam logic [31:0] ADDR_EXP_BASE    = 32'h1F00_0000;
   localparam logic [31:0] ADDR_IO_LO       = 32'h1F80_0100;
   localparam logic [31:0] ADDR_IO_HI       = 32'h1F88_0000;
   localparam logic [31:0] ADDR_ROM_SIZE    = 32'h1F80_1010;
   localparam logic [31:0] ADDR_COM_DELAY   = 32'h1F80_1020;
   localparam logic [31:0] ADDR_RAM_SIZE    = 32'h1F80_1060;
   localparam logic [31:0] ADDR_IRQ_STAT    = 32'h1F80_1070;
   localparam logic [31:0] ADDR_IRQ_MASK    = 32'h1F80_1074;
   localparam logic [31:0] ADDR_DMA_BASE    = 32'h1F80_1080;
   localparam logic [31:0] ADDR_GPU0        = 32'h1F80_1810;
   localparam logic [31:0] ADDR_GPU1        = 32'h1F80_1814;
   localparam logic [31:0] ADDR_SPU_BASE    = 32'h1F80_1C00;
   localparam logic [31:0] ADDR_ROM_BASE    = 32'hBFC0_0000;
   localparam logic [31:0] ADDR_CACHE_CTRL  = 32'hFFFE_0130;
   localparam logic [31:0] ADDR_ISO_LIMIT   = 32'h0000_1000;
   localparam logic [31:0] GPU1_READ_VALUE  = 32'h1000_0000;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RAM_RD,
      OP_RAM_WR,
      OP_ROM_RD,
      OP_ROM_WR,
      OP_REG_WR
   } op_type;

   typedef enum logic [1:0] {
      SEL_ROM_SIZE,
      SEL_RAM_SIZE,
      SEL_COM_DELAY,
      SEL_CACHE_CTRL
   } store_sel_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [31:0] read_data;
      logic [9:0]  device_offset;
      logic [2:0]  dma_channel;
      logic [3:0]  dma_register;
      logic [31:0] forward_data;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      store_sel_type     sel;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       wdata;
      rsp_type           rsp;
   } entry_type;

endpackage

### src/mmbd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module mmbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/mmbd_front.sv
// Front end: takes bus accesses, decodes the address map and builds queue entries.
// Holds the cache isolation register. Depends on mmbd_pkg.
module mmbd_front import mmbd_pkg::*; #(
   parameter int RAM_WORDS = RAM_WORDS_DEF,
   parameter int ROM_WORDS = ROM_WORDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  logic      csr_data,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_data
);

   localparam logic [31:0] RAM_BYTES = 32'(RAM_WORDS * 4);
   localparam logic [31:0] ROM_BYTES = 32'(ROM_WORDS * 4);
   localparam logic [31:0] ROM_LIMIT = 32'(ROM_WORDS);

   logic        isolated_ff;
   logic        isolated_in;
   logic [31:0] a;
   logic        in_kuseg;
   logic        in_kseg0;
   logic        in_kseg1;
   logic        in_exp;
   logic        in_dma;
   logic        in_spu;
   logic        in_rom;
   logic        in_io;
   entry_type   e;

   assign csr_ready   = 1'b1;
   assign isolated_in = (csr_valid) ? csr_data : isolated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isolated_ff <= 1'b0;
      end else begin
         isolated_ff <= isolated_in;
      end
   end

   assign a        = req_data.address;
   assign in_kuseg = a < RAM_BYTES;
   assign in_kseg0 = (a[31:29] == 3'b100) && ({3'b000, a[28:0]} < RAM_BYTES);
   assign in_kseg1 = (a[31:29] == 3'b101) && ({3'b000, a[28:0]} < RAM_BYTES);
   assign in_exp   = a[31:8] == ADDR_EXP_BASE[31:8];
   assign in_dma   = a[31:7] == ADDR_DMA_BASE[31:7];
   assign in_spu   = a[31:10] == ADDR_SPU_BASE[31:10];
   assign in_rom   = (a >= ADDR_ROM_BASE) && ((a - ADDR_ROM_BASE) < ROM_BYTES);
   assign in_io    = (a >= ADDR_IO_LO) && (a < ADDR_IO_HI);

   always_comb begin
      e                   = '0;
      e.op                = OP_NONE;
      e.sel               = SEL_ROM_SIZE;
      e.idx               = a[IDX_W+1:2];
      e.wdata             = req_data.write_data;
      e.rsp.target        = TGT_UNMAPPED;
      e.rsp.read_data     = '1;
      unique case (req_data.cmd)
         CMD_READ: begin
            priority if (in_kuseg || in_kseg0 || in_kseg1) begin
               e.op              = OP_RAM_RD;
               e.rsp.target      = TGT_RAM;
               e.rsp.read_data   = '0;
            end else if (in_exp) begin
               e.rsp.target      = TGT_EXP;
            end else if (a == ADDR_IRQ_STAT) begin
               e.rsp.target      = TGT_IRQ_STAT;
               e.rsp.read_data   = '0;
            end else if (a == ADDR_IRQ_MASK) begin
               e.rsp.target      = TGT_IRQ_MASK;
               e.rsp.read_data   = '0;
            end else if (in_dma) begin
               e.rsp.target       = TGT_DMA;
               e.rsp.read_data    = '0;
               e.rsp.dma_channel  = a[6:4];
               e.rsp.dma_register = a[3:0];
            end else if (a == ADDR_GPU0) begin
               e.rsp.target      = TGT_GPU;
               e.rsp.read_data   = '0;
            end else if (a == ADDR_GPU1) begin
               e.rsp.target      = TGT_GPU;
               e.rsp.read_data   = GPU1_READ_VALUE;
            end else if (in_spu) begin
               e.rsp.target        = TGT_SPU;
               e.rsp.read_data     = '0;
               e.rsp.device_offset = a[9:0];
            end else if (in_rom) begin
               e.op              = OP_ROM_RD;
               e.rsp.target      = TGT_ROM;
               e.rsp.read_data   = '0;
            end else begin
               e.rsp.target      = TGT_UNMAPPED;
            end
         end
         CMD_WRITE: begin
            priority if (in_kuseg) begin
               e.rsp.read_data = '0;
               if (isolated_ff && (a < ADDR_ISO_LIMIT)) begin
                  e.rsp.target = TGT_DISCARD;
               end else begin
                  e.op         = OP_RAM_WR;
                  e.rsp.target = TGT_RAM;
               end
            end else if (in_exp) begin
               e.rsp.target = TGT_EXP;
            end else if (in_io) begin
               priority if (a == ADDR_ROM_SIZE) begin
                  e.op              = OP_REG_WR;
                  e.sel             = SEL_ROM_SIZE;
                  e.rsp.target      = TGT_MEMCTRL;
                  e.rsp.read_data   = '0;
               end else if (a == ADDR_RAM_SIZE) begin
                  e.op              = OP_REG_WR;
                  e.sel             = SEL_RAM_SIZE;
                  e.rsp.target      = TGT_MEMCTRL;
                  e.rsp.read_data   = '0;
               end else if (a == ADDR_COM_DELAY) begin
                  e.op              = OP_REG_WR;
                  e.sel             = SEL_COM_DELAY;
                  e.rsp.target      = TGT_MEMCTRL;
                  e.rsp.read_data   = '0;
               end else if (in_spu) begin
                  e.rsp.target        = TGT_SPU;
                  e.rsp.read_data     = '0;
                  e.rsp.device_offset = a[9:0];
                  e.rsp.forward_data  = req_data.write_data;
               end else begin
                  e.rsp.target = TGT_UNMAPPED;
               end
            end else if (in_kseg0 || in_kseg1) begin
               e.op            = OP_RAM_WR;
               e.rsp.target    = TGT_RAM;
               e.rsp.read_data = '0;
            end else if (a == ADDR_CACHE_CTRL) begin
               e.op            = OP_REG_WR;
               e.sel           = SEL_CACHE_CTRL;
               e.rsp.target    = TGT_CACHECTRL;
               e.rsp.read_data = '0;
            end else begin
               e.rsp.target = TGT_UNMAPPED;
            end
         end
         CMD_LOAD: begin
            if (a < ROM_LIMIT) begin
               e.op            = OP_ROM_WR;
               e.idx           = a[IDX_W-1:0];
               e.rsp.target    = TGT_ROM;
               e.rsp.read_data = '0;
            end
         end
         CMD_RSVD: begin
            e.rsp.target = TGT_UNMAPPED;
         end
         default: begin
            e.rsp.target = TGT_UNMAPPED;
         end
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign push_data  = e;

endmodule

### src/mmbd_queue.sv
// Short FIFO of decoded entries between front and back end.
// Depends on mmbd_pkg.
module mmbd_queue import mmbd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      head_valid,
   output entry_type head_data,
   input  logic      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             take;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign take       = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/mmbd_back.sv
// Back end: executes queue entries against RAM, ROM and the control stores,
// and drives the result register. Depends on mmbd_pkg and mmbd_ram.
module mmbd_back import mmbd_pkg::*; #(
   parameter int RAM_WORDS = RAM_WORDS_DEF,
   parameter int ROM_WORDS = ROM_WORDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_data,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int RAM_AW = $clog2(RAM_WORDS);
   localparam int ROM_AW = $clog2(ROM_WORDS);

   logic        ram_en;
   logic        ram_we;
   logic [31:0] ram_rdata;
   logic        rom_en;
   logic        rom_we;
   logic [31:0] rom_rdata;
   logic        is_read;

   logic        pend_ff;
   logic        pend_in;
   logic        pend_rom_ff;
   rsp_type     pend_rsp_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_ff;
   rsp_type     out_in;

   logic [31:0] rom_size_ff;
   logic [31:0] ram_size_ff;
   logic [31:0] com_delay_ff;
   logic [31:0] cache_ctrl_ff;

   assign is_read = (head_data.op == OP_RAM_RD) || (head_data.op == OP_ROM_RD);
   // Take an entry when no read is in flight and the result slot is empty or frees this cycle.
   assign pop     = head_valid && !pend_ff && (!out_valid_ff || rsp_ready);

   assign ram_en = pop && ((head_data.op == OP_RAM_RD) || (head_data.op == OP_RAM_WR));
   assign ram_we = head_data.op == OP_RAM_WR;
   assign rom_en = pop && ((head_data.op == OP_ROM_RD) || (head_data.op == OP_ROM_WR));
   assign rom_we = head_data.op == OP_ROM_WR;

   mmbd_ram #(
      .WIDTH(32),
      .DEPTH(RAM_WORDS)
   ) u_main_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (head_data.idx[RAM_AW-1:0]),
      .wdata(head_data.wdata),
      .rdata(ram_rdata)
   );

   mmbd_ram #(
      .WIDTH(32),
      .DEPTH(ROM_WORDS)
   ) u_boot_rom (
      .clock(clock),
      .en   (rom_en),
      .we   (rom_we),
      .addr (head_data.idx[ROM_AW-1:0]),
      .wdata(head_data.wdata),
      .rdata(rom_rdata)
   );

   assign pend_in = pop && is_read;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (pend_ff) begin
         out_in           = pend_rsp_ff;
         out_in.read_data = pend_rom_ff ? rom_rdata : ram_rdata;
         out_valid_in     = 1'b1;
      end else if (pop && !is_read) begin
         out_in       = head_data.rsp;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         rom_size_ff   <= '0;
         ram_size_ff   <= '0;
         com_delay_ff  <= '0;
         cache_ctrl_ff <= '0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (pop && (head_data.op == OP_REG_WR)) begin
            unique case (head_data.sel)
               SEL_ROM_SIZE:   rom_size_ff   <= head_data.wdata;
               SEL_RAM_SIZE:   ram_size_ff   <= head_data.wdata;
               SEL_COM_DELAY:  com_delay_ff  <= head_data.wdata;
               SEL_CACHE_CTRL: cache_ctrl_ff <= head_data.wdata;
               default:        rom_size_ff   <= rom_size_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (pend_in) begin
         pend_rsp_ff <= head_data.rsp;
         pend_rom_ff <= head_data.op == OP_ROM_RD;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### src/memory_map_bus_decoder.sv
// Memory map bus decoder: how to use it.
// req_*: one bus access per transfer (read, write or boot ROM word load), valid/ready.
// rsp_*: exactly one result per access, in order, valid/ready, from an output register.
// csr_*: one-bit cache isolation write; always ready, write only while the block is idle.
// The front end decodes each address in the transfer cycle and pushes the decoded
// access into a two-entry queue; the back end executes it against RAM, ROM or the
// control stores. Each result passes through the queue entry and the result register;
// RAM and ROM reads also pass through the registered read port of the memory.
// Throughput: one access per cycle for writes, loads and register or device accesses
// while the receiver takes results; a RAM or ROM read holds off the next access until
// its data is back, set by the registered read port of the single-port memories.
// Reset clears the queue, the result valid bit, the memory-control and cache-control
// words and the isolation bit; RAM and ROM contents stay undefined until written.
// If the receiver stalls, the result is held and the queue fills; req_ready drops
// once both queue entries are taken.
// Depends on mmbd_pkg, mmbd_front, mmbd_queue, mmbd_back and mmbd_ram.
module memory_map_bus_decoder import mmbd_pkg::*; #(
   parameter int RAM_WORDS = RAM_WORDS_DEF,
   parameter int ROM_WORDS = ROM_WORDS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Decoded accesses travelling from front to back
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      head_valid;
   entry_type head_data;
   logic      pop;

   // Decode the address map and hold the isolation bit
   mmbd_front #(
      .RAM_WORDS(RAM_WORDS),
      .ROM_WORDS(ROM_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   // Decouple the two halves so each can stall on its own
   mmbd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop)
   );

   // Execute in order and hold the result until transferred
   mmbd_back #(
      .RAM_WORDS(RAM_WORDS),
      .ROM_WORDS(ROM_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/memory_map_bus_decoder_tb.sv
// Self-checking bench for memory_map_bus_decoder: a directed table of bus accesses, then
// random phases under both isolation settings; each result is checked against its row or a local decode.
// Depends on mmbd_pkg and the memory_map_bus_decoder RTL; reads no files.
module memory_map_bus_decoder_tb;
   import mmbd_pkg::*;

   localparam int RAM_WORDS = RAM_WORDS_DEF;
   localparam int ROM_WORDS = ROM_WORDS_DEF;
   localparam logic [31:0] RAM_BYTES  = 32'(RAM_WORDS * 4);
   localparam logic [31:0] ROM_BYTES  = 32'(ROM_WORDS * 4);
   localparam logic [31:0] KSEG0_BASE = 32'h8000_0000;
   localparam logic [31:0] KSEG1_BASE = 32'hA000_0000;
   localparam logic [31:0] EXP_BYTES  = 32'h0000_0100;
   localparam logic [31:0] DMA_BYTES  = 32'h0000_0080;
   localparam logic [31:0] SPU_BYTES  = 32'h0000_0400;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 325;
   localparam int CALM_PHASE  = 3;
   localparam int IDLE_PCT    = 24;
   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_MAX  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // One row of the directed table; typed rows carry their own expected target and data.
   typedef struct {
      logic        iso;
      logic [1:0]  cmd;
      logic [31:0] addr;
      logic [31:0] data;
      bit          typed;
      logic [3:0]  target;
      logic [31:0] read_data;
   } plan_step_type;

   plan_step_type access_plan[$];

   // Local copy of the block's storage and its isolation bit.
   logic [31:0] ram_image [int unsigned];
   logic [31:0] rom_image [int unsigned];
   int unsigned ram_filled[$];
   int unsigned rom_filled[$];
   logic        isolated = 1'b0;
   logic [31:0] rom_size_word, ram_size_word, delay_word, cache_ctrl_word;

   rsp_type     pending_results[$];
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned quiet = 0;
   int unsigned target_hits[16];
   bit          calm = 1'b0;

   memory_map_bus_decoder #(
      .RAM_WORDS (RAM_WORDS),
      .ROM_WORDS (ROM_WORDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Map an address onto a RAM word through any of the three mirrors.
   function automatic bit ram_slot(input logic [31:0] a, output int unsigned idx);
      logic [31:0] off;
      idx = 0;
      if (a < RAM_BYTES) off = a;
      else if (a >= KSEG0_BASE && a - KSEG0_BASE < RAM_BYTES) off = a - KSEG0_BASE;
      else if (a >= KSEG1_BASE && a - KSEG1_BASE < RAM_BYTES) off = a - KSEG1_BASE;
      else return 1'b0;
      idx = off >> 2;
      return 1'b1;
   endfunction

   function automatic bit rom_slot(input logic [31:0] a, output int unsigned idx);
      idx = 0;
      if (a < ADDR_ROM_BASE || a - ADDR_ROM_BASE >= ROM_BYTES) return 1'b0;
      idx = (a - ADDR_ROM_BASE) >> 2;
      return 1'b1;
   endfunction

   function automatic void keep_ram_word(input int unsigned idx, input logic [31:0] d);
      if (!ram_image.exists(idx)) ram_filled.push_back(idx);
      ram_image[idx] = d;
   endfunction

   function automatic rsp_type plain_result(input logic [3:0] t, input logic [31:0] rd);
      rsp_type o;
      o = '0;
      o.target = t;
      o.read_data = rd;
      return o;
   endfunction

   // Decode one access against the memory map and apply its side effects.
   function automatic rsp_type predict_bus_access(input req_type r);
      rsp_type     o;
      logic [31:0] a;
      logic [31:0] d;
      logic [31:0] off;
      int unsigned idx;
      a = r.address;
      d = r.write_data;
      o = '0;
      if (r.cmd == CMD_READ) begin
         if (a < RAM_BYTES) begin
            o.target = TGT_RAM;
            o.read_data = ram_image[a >> 2];
         end else if (a >= ADDR_EXP_BASE && a < ADDR_EXP_BASE + EXP_BYTES) begin
            o = plain_result(TGT_EXP, ALL_ONES);
         end else if (a == ADDR_IRQ_STAT) begin
            o.target = TGT_IRQ_STAT;
         end else if (a == ADDR_IRQ_MASK) begin
            o.target = TGT_IRQ_MASK;
         end else if (a >= ADDR_DMA_BASE && a < ADDR_DMA_BASE + DMA_BYTES) begin
            off = a - ADDR_DMA_BASE;
            o.target = TGT_DMA;
            o.dma_channel = off[6:4];
            o.dma_register = a[3:0];
         end else if (a == ADDR_GPU0) begin
            o.target = TGT_GPU;
         end else if (a == ADDR_GPU1) begin
            o = plain_result(TGT_GPU, GPU1_READ_VALUE);
         end else if (a >= ADDR_SPU_BASE && a < ADDR_SPU_BASE + SPU_BYTES) begin
            off = a - ADDR_SPU_BASE;
            o.target = TGT_SPU;
            o.device_offset = off[9:0];
         end else if (ram_slot(a, idx)) begin
            o = plain_result(TGT_RAM, ram_image[idx]);
         end else if (rom_slot(a, idx)) begin
            o = plain_result(TGT_ROM, rom_image[idx]);
         end else begin
            o = plain_result(TGT_UNMAPPED, ALL_ONES);
         end
      end else if (r.cmd == CMD_WRITE) begin
         if (a < RAM_BYTES && isolated && a < ADDR_ISO_LIMIT) begin
            o.target = TGT_DISCARD;
         end else if (a < RAM_BYTES) begin
            keep_ram_word(a >> 2, d);
            o.target = TGT_RAM;
         end else if (a >= ADDR_EXP_BASE && a < ADDR_EXP_BASE + EXP_BYTES) begin
            o = plain_result(TGT_EXP, ALL_ONES);
         end else if (a >= ADDR_IO_LO && a < ADDR_IO_HI) begin
            if (a == ADDR_ROM_SIZE) begin
               rom_size_word = d;
               o.target = TGT_MEMCTRL;
            end else if (a == ADDR_RAM_SIZE) begin
               ram_size_word = d;
               o.target = TGT_MEMCTRL;
            end else if (a == ADDR_COM_DELAY) begin
               delay_word = d;
               o.target = TGT_MEMCTRL;
            end else if (a >= ADDR_SPU_BASE && a < ADDR_SPU_BASE + SPU_BYTES) begin
               off = a - ADDR_SPU_BASE;
               o.target = TGT_SPU;
               o.device_offset = off[9:0];
               o.forward_data = d;
            end else begin
               // irq, dma and gpu ports take no writes
               o = plain_result(TGT_UNMAPPED, ALL_ONES);
            end
         end else if (ram_slot(a, idx)) begin
            keep_ram_word(idx, d);
            o.target = TGT_RAM;
         end else if (a == ADDR_CACHE_CTRL) begin
            cache_ctrl_word = d;
            o.target = TGT_CACHECTRL;
         end else begin
            o = plain_result(TGT_UNMAPPED, ALL_ONES);
         end
      end else if (r.cmd == CMD_LOAD && a < ROM_WORDS) begin
         if (!rom_image.exists(a)) rom_filled.push_back(a);
         rom_image[a] = d;
         o.target = TGT_ROM;
      end else begin
         o = plain_result(TGT_UNMAPPED, ALL_ONES);
      end
      return o;
   endfunction

   // Pick a RAM mirror at random and a random byte lane within the word.
   function automatic logic [31:0] ram_alias(input int unsigned idx);
      logic [31:0] base;
      case ($urandom_range(0, 2))
         0: base = 32'h0;
         1: base = KSEG0_BASE;
         default: base = KSEG1_BASE;
      endcase
      return base + (idx << 2) + $urandom_range(0, 3);
   endfunction

   // Mostly well-formed traffic: RAM writes and read-backs, ROM loads and reads, device
   // and register addresses around their edges, plus a tenth of pure noise.
   function automatic req_type random_access();
      req_type     r;
      int unsigned pick;
      int unsigned idx;
      pick = $urandom_range(0, 99);
      r.cmd = CMD_READ;
      r.address = $urandom;
      r.write_data = $urandom;
      if (pick < 25) begin
         r.cmd = CMD_WRITE;
         // a quarter land in the first page, where isolation bites
         if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, 1023);
         else idx = $urandom_range(0, RAM_WORDS - 1);
         r.address = ram_alias(idx);
      end else if (pick < 50 && ram_filled.size() != 0) begin
         r.address = ram_alias(ram_filled[$urandom_range(0, ram_filled.size() - 1)]);
      end else if (pick < 60) begin
         r.cmd = CMD_LOAD;
         if ($urandom_range(0, 9) != 0) r.address = $urandom_range(0, ROM_WORDS - 1);
      end else if (pick < 70 && rom_filled.size() != 0) begin
         idx = rom_filled[$urandom_range(0, rom_filled.size() - 1)];
         r.address = ADDR_ROM_BASE + (idx << 2) + $urandom_range(0, 3);
      end else if (pick < 90) begin
         if ($urandom_range(0, 15) == 0) r.cmd = CMD_RSVD;
         else if ($urandom_range(0, 1) == 0) r.cmd = CMD_WRITE;
         case ($urandom_range(0, 9))
            0: r.address = ADDR_EXP_BASE - 4 + $urandom_range(0, 263);
            1: r.address = ($urandom_range(0, 1) == 0) ? ADDR_IRQ_STAT : ADDR_IRQ_MASK;
            2: r.address = ADDR_DMA_BASE - 4 + $urandom_range(0, 135);
            3: r.address = ($urandom_range(0, 1) == 0) ? ADDR_GPU0 : ADDR_GPU1;
            4: r.address = ADDR_SPU_BASE - 4 + $urandom_range(0, 1031);
            5: begin
               case ($urandom_range(0, 2))
                  0: r.address = ADDR_ROM_SIZE;
                  1: r.address = ADDR_RAM_SIZE;
                  default: r.address = ADDR_COM_DELAY;
               endcase
            end
            6: r.address = ADDR_CACHE_CTRL;
            7: r.address = ADDR_IO_LO + $urandom_range(0, ADDR_IO_HI - ADDR_IO_LO);
            8: r.address = RAM_BYTES - 8 + $urandom_range(0, 15);
            default: r.address = ADDR_ROM_BASE + ROM_BYTES - 8 + $urandom_range(0, 15);
         endcase
      end else begin
         r.cmd = 2'($urandom_range(0, 3));
      end
      // never read a RAM or ROM word that holds nothing yet: write it instead
      if (r.cmd == CMD_READ &&
          ((ram_slot(r.address, idx) && !ram_image.exists(idx)) ||
           (rom_slot(r.address, idx) && !rom_image.exists(idx))))
         r.cmd = CMD_WRITE;
      return r;
   endfunction

   task automatic add_checked(input logic iso, input logic [1:0] cmd, input logic [31:0] addr,
                              input logic [31:0] data, input logic [3:0] t,
                              input logic [31:0] rd);
      plan_step_type s;
      s = '{iso, cmd, addr, data, 1'b1, t, rd};
      access_plan.push_back(s);
   endtask

   task automatic add_predicted(input logic iso, input logic [1:0] cmd,
                                input logic [31:0] addr, input logic [31:0] data);
      plan_step_type s;
      s = '{iso, cmd, addr, data, 1'b0, TGT_RAM, 32'h0};
      access_plan.push_back(s);
   endtask

   // Present one access, hold it until the transfer, then queue its expected result.
   task automatic send_access(input req_type r, input bit typed, input rsp_type typed_want);
      rsp_type want;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      want = predict_bus_access(r);
      pending_results.push_back(typed ? typed_want : want);
   endtask

   // Drop valid and let every outstanding result drain before touching the register.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_isolation(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      isolated = v;
      csr_valid <= 1'b0;
   endtask

   // Result side: check each transfer, randomise ready, and watch for a stalled run.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            target_hits[rsp_data.target]++;
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("unexpected result: target %0d data %h", rsp_data.target,
                           rsp_data.read_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.target !== want.target ||
                   rsp_data.read_data !== want.read_data ||
                   rsp_data.device_offset !== want.device_offset ||
                   rsp_data.dma_channel !== want.dma_channel ||
                   rsp_data.dma_register !== want.dma_register ||
                   rsp_data.forward_data !== want.forward_data) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("mismatch: want tgt %0d rd %h off %h ch %0d reg %h fwd %h",
                              want.target, want.read_data, want.device_offset,
                              want.dma_channel, want.dma_register, want.forward_data);
                     $display("          got  tgt %0d rd %h off %h ch %0d reg %h fwd %h",
                              rsp_data.target, rsp_data.read_data, rsp_data.device_offset,
                              rsp_data.dma_channel, rsp_data.dma_register,
                              rsp_data.forward_data);
                  end
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      rsp_type typed_want;
      // Directed table: mirrors, map edges, ROM index bounds, device ports, register
      // write-only and read-only addresses, the unused command, then cache isolation.
      add_checked(1'b0, CMD_WRITE, 32'h0000_0000, ALL_ONES, TGT_RAM, 32'h0);
      add_checked(1'b0, CMD_READ, 32'h0000_0003, 32'h0, TGT_RAM, ALL_ONES);
      add_checked(1'b0, CMD_WRITE, 32'h001F_FFFC, 32'h0000_0001, TGT_RAM, 32'h0);
      add_predicted(1'b0, CMD_READ, 32'h801F_FFFC, 32'h0);
      add_checked(1'b0, CMD_WRITE, 32'hA000_0004, 32'hA5A5_5A5A, TGT_RAM, 32'h0);
      add_checked(1'b0, CMD_READ, 32'h0020_0000, 32'h0, TGT_UNMAPPED, ALL_ONES);
      add_checked(1'b0, CMD_LOAD, 32'h0000_0000, 32'h1234_5678, TGT_ROM, 32'h0);
      add_checked(1'b0, CMD_LOAD, 32'h0001_FFFF, 32'h8765_4321, TGT_ROM, 32'h0);
      add_checked(1'b0, CMD_LOAD, 32'h0002_0000, 32'hDEAD_BEEF, TGT_UNMAPPED, ALL_ONES);
      add_predicted(1'b0, CMD_READ, 32'hBFC7_FFFD, 32'h0);
      add_checked(1'b0, CMD_READ, 32'h1F00_00FF, 32'h0, TGT_EXP, ALL_ONES);
      add_checked(1'b0, CMD_WRITE, 32'h1F00_0000, 32'h5555_AAAA, TGT_EXP, ALL_ONES);
      add_checked(1'b0, CMD_READ, ADDR_IRQ_STAT, 32'h0, TGT_IRQ_STAT, 32'h0);
      add_checked(1'b0, CMD_READ, ADDR_IRQ_MASK, 32'h0, TGT_IRQ_MASK, 32'h0);
      add_predicted(1'b0, CMD_READ, 32'h1F80_10FF, 32'h0);
      add_checked(1'b0, CMD_WRITE, ADDR_DMA_BASE, 32'h0F0F_0F0F, TGT_UNMAPPED, ALL_ONES);
      add_checked(1'b0, CMD_READ, ADDR_GPU1, 32'h0, TGT_GPU, GPU1_READ_VALUE);
      add_predicted(1'b0, CMD_WRITE, 32'h1F80_1FFF, 32'hCAFE_F00D);
      add_checked(1'b0, CMD_WRITE, ADDR_ROM_SIZE, 32'h0013_243F, TGT_MEMCTRL, 32'h0);
      add_checked(1'b0, CMD_READ, ADDR_CACHE_CTRL, 32'h0, TGT_UNMAPPED, ALL_ONES);
      add_checked(1'b0, CMD_WRITE, ADDR_CACHE_CTRL, 32'h0000_0804, TGT_CACHECTRL, 32'h0);
      add_checked(1'b0, CMD_RSVD, ALL_ONES, ALL_ONES, TGT_UNMAPPED, ALL_ONES);
      add_checked(1'b1, CMD_WRITE, 32'h0000_0FFC, 32'h1111_1111, TGT_DISCARD, 32'h0);
      add_checked(1'b1, CMD_WRITE, ADDR_ISO_LIMIT, 32'h2222_2222, TGT_RAM, 32'h0);
      add_predicted(1'b1, CMD_READ, 32'h0000_0000, 32'h0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_isolation(1'b0);

      foreach (access_plan[i]) begin
         if (access_plan[i].iso != isolated) begin
            settle();
            set_isolation(access_plan[i].iso);
         end
         r.cmd = access_plan[i].cmd;
         r.address = access_plan[i].addr;
         r.write_data = access_plan[i].data;
         typed_want = plain_result(access_plan[i].target, access_plan[i].read_data);
         send_access(r, access_plan[i].typed, typed_want);
      end

      // Random phases alternate the isolation bit; one phase runs with no idling at all.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         set_isolation((p % 2) == 1);
         calm = (p == CALM_PHASE);
         repeat (PHASE_ITEMS) begin
            r = random_access();
            send_access(r, 1'b0, '0);
         end
      end
      settle();
      calm = 1'b0;

      $display("%0d accesses (%0d directed) under both isolation settings, %0d results checked",
               items_sent, access_plan.size(), results_seen);
      $display("targets: ram %0d rom %0d exp %0d irq %0d dma %0d gpu %0d spu %0d mem %0d",
               target_hits[TGT_RAM], target_hits[TGT_ROM], target_hits[TGT_EXP],
               target_hits[TGT_IRQ_STAT] + target_hits[TGT_IRQ_MASK], target_hits[TGT_DMA],
               target_hits[TGT_GPU], target_hits[TGT_SPU], target_hits[TGT_MEMCTRL]);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
